// ----- src/fsmd_pkg.sv -----
// Shared types, constants and register codes of the metal discriminator.
package fsmd_pkg;

   localparam int TIME_BITS_DEFAULT = 32;
   localparam int TS_W              = 32;
   localparam int CFG_W             = 16;
   localparam int CSR_ADDR_W        = 3;
   localparam int LEVEL_W           = 16;
   localparam int REQ_TDATA_W       = 40;
   localparam int RSP_TDATA_W       = 40;

   // Reciprocal of three for a 16-bit operand: x / 3 = (x * 43691) >> 17.
   localparam logic [15:0] DIV3_RECIP = 16'hAAAB;
   localparam int          DIV3_SHIFT = 17;

   localparam logic [LEVEL_W-1:0] STRONG_LIMIT = 16'd3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_WINDOW_EDGES    = 3'd0,
      REG_SENSITIVITY     = 3'd1,
      REG_BALANCE_LIMIT   = 3'd2,
      REG_TONE_FERROUS    = 3'd3,
      REG_TONE_NONFERROUS = 3'd4
   } reg_index_type;

   localparam logic [CFG_W-1:0] WINDOW_EDGES_RST    = 16'd2000;
   localparam logic [CFG_W-1:0] SENSITIVITY_RST     = 16'd3;
   localparam logic [CFG_W-1:0] BALANCE_LIMIT_RST   = 16'd1000;
   localparam logic [CFG_W-1:0] TONE_FERROUS_RST    = 16'd500;
   localparam logic [CFG_W-1:0] TONE_NONFERROUS_RST = 16'd900;

   typedef enum logic [1:0] {
      OP_EDGE    = 2'd0,
      OP_BALANCE = 2'd1,
      OP_TICK    = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CHECKS_NONE  = 2'd0,
      CHECKS_FIRST = 2'd1,
      CHECKS_DONE  = 2'd2
   } checks_type;

   typedef struct packed {
      logic [CFG_W-1:0] window_edges;
      logic [CFG_W-1:0] sensitivity;
      logic [CFG_W-1:0] balance_limit;
      logic [CFG_W-1:0] tone_ferrous;
      logic [CFG_W-1:0] tone_nonferrous;
   } cfg_type;

   // Declared from the highest bit down so that opcode sits in the lowest bits.
   typedef struct packed {
      logic [5:0]      pad;
      logic [TS_W-1:0] timestamp_us;
      op_type          opcode;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]         pad;
      logic               window_done;
      logic               balancing;
      logic [CFG_W-1:0]   tone_code;
      logic               alert;
      logic               strong_res;
      logic               ferrous;
      logic [LEVEL_W-1:0] intensity;
   } rsp_payload_type;

endpackage

// ----- src/fsmd_cfg.sv -----
// Configuration register file of the metal discriminator.
module fsmd_cfg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [fsmd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [fsmd_pkg::CFG_W-1:0]     csr_wdata,
   output fsmd_pkg::cfg_type              cfg
);
   import fsmd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_addr))
            REG_WINDOW_EDGES:    cfg_in.window_edges    = csr_wdata;
            REG_SENSITIVITY:     cfg_in.sensitivity     = csr_wdata;
            REG_BALANCE_LIMIT:   cfg_in.balance_limit   = csr_wdata;
            REG_TONE_FERROUS:    cfg_in.tone_ferrous    = csr_wdata;
            REG_TONE_NONFERROUS: cfg_in.tone_nonferrous = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_edges    <= WINDOW_EDGES_RST;
         cfg_ff.sensitivity     <= SENSITIVITY_RST;
         cfg_ff.balance_limit   <= BALANCE_LIMIT_RST;
         cfg_ff.tone_ferrous    <= TONE_FERROUS_RST;
         cfg_ff.tone_nonferrous <= TONE_NONFERROUS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/fsmd_core.sv -----
// Discriminator state and its update for each item.
module fsmd_core #(
   parameter int TIME_BITS = fsmd_pkg::TIME_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  fsmd_pkg::op_type          op,
   input  logic [fsmd_pkg::TS_W-1:0] timestamp_us,
   input  fsmd_pkg::cfg_type         cfg,
   output fsmd_pkg::rsp_payload_type result
);
   import fsmd_pkg::*;

   logic [CFG_W-1:0]     edge_count_ff, edge_count_in;
   logic [TIME_BITS-1:0] window_start_ff, window_start_in;
   logic [TIME_BITS-1:0] tracked_ff, tracked_in;
   logic [TIME_BITS-1:0] baseline_ff, baseline_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [CFG_W-1:0]     quiet_ff, quiet_in;
   logic                 first_window_ff, first_window_in;
   logic                 ferrous_ff, ferrous_in;
   logic                 strong_ff, strong_in;
   logic                 startup_ff, startup_in;
   checks_type           checks_ff, checks_in;

   logic [TIME_BITS+TS_W-1:0] ts_ext;
   logic [TIME_BITS-1:0]      ts_w;
   logic [CFG_W-1:0]          cnt_inc;
   logic [31:0]               prod;
   logic [LEVEL_W-1:0]        third;
   logic [LEVEL_W-1:0]        step_amt;
   logic [TIME_BITS-1:0]      step_t;
   logic [TIME_BITS-1:0]      frq;
   logic [TIME_BITS:0]        diff_tf;
   logic [TIME_BITS:0]        diff_ft;
   logic                      dec_go;
   logic                      inc_go;
   logic [TIME_BITS-1:0]      dec_val;
   logic [TIME_BITS-1:0]      inc_val;
   logic [TIME_BITS-1:0]      trk_new;
   logic                      ferrous_c;
   logic [TIME_BITS-1:0]      mag;
   logic [LEVEL_W-1:0]        level_c;
   logic                      match;
   logic                      done;
   logic                      alert;

   assign ts_ext  = {{TIME_BITS{1'b0}}, timestamp_us};
   assign ts_w    = ts_ext[TIME_BITS-1:0];
   assign cnt_inc = edge_count_ff + CFG_W'(1);

   assign prod     = 32'(level_ff) * 32'(DIV3_RECIP);
   assign third    = LEVEL_W'(prod >> DIV3_SHIFT);
   assign step_amt = LEVEL_W'(1) + ((strong_ff && !startup_ff) ? third : '0);
   assign step_t   = TIME_BITS'(step_amt);

   assign frq     = ts_w - window_start_ff;
   assign diff_tf = {1'b0, tracked_ff} - {1'b0, frq};
   assign diff_ft = {1'b0, frq} - {1'b0, tracked_ff};
   assign dec_go  = !diff_tf[TIME_BITS] && (diff_tf[TIME_BITS-1:0] > TIME_BITS'(1));
   assign inc_go  = !diff_ft[TIME_BITS] && (diff_ft[TIME_BITS-1:0] > TIME_BITS'(1));
   assign dec_val = (tracked_ff > step_t) ? tracked_ff - step_t : '0;
   assign inc_val = (~tracked_ff > step_t) ? tracked_ff + step_t : '1;

   always_comb begin
      priority if (first_window_ff) begin
         trk_new = frq;
      end else if (dec_go) begin
         trk_new = dec_val;
      end else if (inc_go) begin
         trk_new = inc_val;
      end else begin
         trk_new = tracked_ff;
      end
   end

   assign ferrous_c = baseline_ff >= trk_new;
   assign mag       = ferrous_c ? baseline_ff - trk_new : trk_new - baseline_ff;
   assign level_c   = ((mag >> LEVEL_W) != '0) ? '1 : mag[LEVEL_W-1:0];
   assign match     = tracked_ff == baseline_ff;

   always_comb begin
      edge_count_in   = edge_count_ff;
      window_start_in = window_start_ff;
      tracked_in      = tracked_ff;
      baseline_in     = baseline_ff;
      level_in        = level_ff;
      quiet_in        = quiet_ff;
      first_window_in = first_window_ff;
      ferrous_in      = ferrous_ff;
      strong_in       = strong_ff;
      startup_in      = startup_ff;
      checks_in       = checks_ff;
      done            = 1'b0;
      unique case (op)
         OP_EDGE: begin
            edge_count_in = cnt_inc;
            if (cnt_inc == CFG_W'(1)) begin
               window_start_in = ts_w;
            end else if (cnt_inc >= cfg.window_edges) begin
               edge_count_in   = '0;
               tracked_in      = trk_new;
               first_window_in = 1'b0;
               ferrous_in      = ferrous_c;
               level_in        = level_c;
               strong_in       = level_c > STRONG_LIMIT;
               done            = 1'b1;
            end
         end
         OP_BALANCE: begin
            if (startup_ff) begin
               if (!match) begin
                  baseline_in = tracked_ff;
               end
               if (checks_ff == CHECKS_NONE) begin
                  checks_in = CHECKS_FIRST;
               end else if (match) begin
                  checks_in  = CHECKS_DONE;
                  startup_in = 1'b0;
               end
            end
         end
         OP_TICK: begin
            if (!startup_ff) begin
               if (!(level_ff > cfg.sensitivity) && (level_ff != '0)) begin
                  if (quiet_ff > cfg.balance_limit) begin
                     baseline_in = tracked_ff;
                     quiet_in    = CFG_W'(1);
                  end else if (quiet_ff != '1) begin
                     quiet_in = quiet_ff + CFG_W'(1);
                  end
               end else begin
                  quiet_in = '0;
               end
            end
         end
         OP_UNUSED: begin
            done = 1'b0;
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff   <= '0;
         window_start_ff <= '0;
         tracked_ff      <= '0;
         baseline_ff     <= '0;
         level_ff        <= '0;
         quiet_ff        <= '0;
         first_window_ff <= 1'b1;
         ferrous_ff      <= 1'b0;
         strong_ff       <= 1'b0;
         startup_ff      <= 1'b1;
         checks_ff       <= CHECKS_NONE;
      end else if (step) begin
         edge_count_ff   <= edge_count_in;
         window_start_ff <= window_start_in;
         tracked_ff      <= tracked_in;
         baseline_ff     <= baseline_in;
         level_ff        <= level_in;
         quiet_ff        <= quiet_in;
         first_window_ff <= first_window_in;
         ferrous_ff      <= ferrous_in;
         strong_ff       <= strong_in;
         startup_ff      <= startup_in;
         checks_ff       <= checks_in;
      end
   end

   assign alert = !startup_in && (level_in > cfg.sensitivity);

   always_comb begin
      result.pad         = '0;
      result.window_done = done;
      result.balancing   = startup_in;
      result.tone_code   = alert ? (ferrous_in ? cfg.tone_ferrous : cfg.tone_nonferrous) : '0;
      result.alert       = alert;
      result.strong_res  = strong_in;
      result.ferrous     = ferrous_in;
      result.intensity   = level_in;
   end

endmodule

// ----- src/frequency_shift_metal_discriminator_top.sv -----
// Top level of the frequency-shift metal discriminator.
//
//   Group   Direction  Handshake            Contents
//   req_    in         req_tvalid/tready    coil edge, balance check or loop tick
//   rsp_    out        rsp_tvalid/tready    intensity, class, flags and tone code
//   csr_    in         csr_we               register writes, no read-back
//
// One item is accepted in every cycle unless the output stalls; each item passes
// through the input register and then the result register.
// The state update for an item is done by the core between them.
// A stalled result holds in the result register while one more item waits
// in the input register.
// Reset is synchronous; it empties the pipeline and resets state and registers.
module frequency_shift_metal_discriminator_top #(
   parameter int TIME_BITS = fsmd_pkg::TIME_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0 up: opcode, timestamp_us, zero fill.
   input  logic [fsmd_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0 up: intensity, ferrous, strong_res, alert, tone_code,
   // balancing, window_done, zero fill.
   output logic [fsmd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_we,
   input  logic [fsmd_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [fsmd_pkg::CFG_W-1:0]       csr_wdata
);
   import fsmd_pkg::*;

   cfg_type         cfg;
   req_payload_type req_item;
   rsp_payload_type result;

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_item_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_item_ff;
   logic            out_free;
   logic            step;
   logic            req_accept;

   assign req_item   = req_payload_type'(req_tdata);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   fsmd_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fsmd_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .op           (in_item_ff.opcode),
      .timestamp_us (in_item_ff.timestamp_us),
      .cfg          (cfg),
      .result       (result)
   );

   always_comb begin
      priority if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      priority if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_item;
      end
      if (step) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff;

endmodule

// ----- src/fsmd_checker.sv -----
// Port-level checks of the metal discriminator and their binding.
module fsmd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [fsmd_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import fsmd_pkg::*;

   rsp_payload_type rsp;

   assign rsp = rsp_payload_type'(rsp_tdata);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result item changed or vanished.");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("Result item shown right after reset.");

   a_strong: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp.strong_res == (rsp.intensity > STRONG_LIMIT))
      else $error("Strong flag disagrees with intensity.");

   a_alert_startup: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.balancing |-> !rsp.alert && (rsp.tone_code == '0))
      else $error("Alert or tone raised during balancing.");

   a_quiet_tone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.alert |-> rsp.tone_code == '0)
      else $error("Tone code without alert.");

endmodule

bind frequency_shift_metal_discriminator_top fsmd_checker u_fsmd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
